// ===== rtl/tga_rle_pkg.sv =====
// ----------------------------------------------------------------------------
// TGA truecolor RLE decoder package
// Shared register indexes, packet constants and the result record.
// ----------------------------------------------------------------------------
package tga_rle_pkg;

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_RLE_MODE        = 2'd0,
    CFG_BYTES_PER_PIXEL = 2'd1,
    CFG_IMAGE_WIDTH     = 2'd2,
    CFG_IMAGE_HEIGHT    = 2'd3
  } cfg_index_t;

  localparam int unsigned CFG_WIDTH = 16;

  // Packet header: bit 7 set marks a run packet, run length is code minus 127
  localparam logic [7:0] RUN_BIAS = 8'd127;

  // One decoded color with its repeat count
  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    logic [7:0] repeat_count;
    logic       image_last;
  } result_t;

endpackage

// ===== rtl/tga_truecolor_rle_decoder.sv =====
// ----------------------------------------------------------------------------
// TGA truecolor RLE decoder
// Turns the pixel-data byte stream of a TGA truecolor image into RGBA results.
// ----------------------------------------------------------------------------
// One input byte is taken per clock, every clock, unless the result side has
// both the output register and the skid register full. Packet header bytes
// and all but the last byte of a pixel produce no result; the last byte of a
// pixel produces one result, registered into the output register, or into the
// skid register while the output register is held. Each result is one
// raw/plain pixel (repeat count 1) or one whole run packet, with the repeat
// count clipped to the pixels left in the image; image_last marks the result
// that completes width*height pixels, and the next byte starts a new image.
// The pixel total is multiplied and registered in the same edge as a width or
// height write, so an item may follow a configuration write directly.
module tga_truecolor_rle_decoder (
  input  logic                               clk,
  input  logic                               rst_n,
  // configuration
  input  logic                               cfg_we,
  input  logic [1:0]                         cfg_index,
  input  logic [tga_rle_pkg::CFG_WIDTH-1:0]  cfg_wdata,
  // input byte channel
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [7:0]                         in_byte,
  // result channel
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [7:0]                         out_red,
  output logic [7:0]                         out_green,
  output logic [7:0]                         out_blue,
  output logic [7:0]                         out_alpha,
  output logic [7:0]                         out_repeat_count,
  output logic                               out_image_last
);

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic        rle_mode_r,  rle_mode_nxt;
  logic [2:0]  bpp_r,       bpp_nxt;
  logic [15:0] width_r,     width_nxt;
  logic [15:0] height_r,    height_nxt;
  logic [31:0] total_r;

  always_comb begin
    rle_mode_nxt = rle_mode_r;
    bpp_nxt      = bpp_r;
    width_nxt    = width_r;
    height_nxt   = height_r;
    if (cfg_we) begin
      case (tga_rle_pkg::cfg_index_t'(cfg_index))
        tga_rle_pkg::CFG_RLE_MODE:        rle_mode_nxt = cfg_wdata[0];
        tga_rle_pkg::CFG_BYTES_PER_PIXEL: bpp_nxt      = cfg_wdata[2:0];
        tga_rle_pkg::CFG_IMAGE_WIDTH:     width_nxt    = cfg_wdata;
        tga_rle_pkg::CFG_IMAGE_HEIGHT:    height_nxt   = cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rle_mode_r <= 1'b1;
      bpp_r      <= 3'd4;
      width_r    <= 16'd1;
      height_r   <= 16'd1;
      total_r    <= 32'd1;
    end else begin
      rle_mode_r <= rle_mode_nxt;
      bpp_r      <= bpp_nxt;
      width_r    <= width_nxt;
      height_r   <= height_nxt;
      // pixel total follows the written dimensions in the same edge
      total_r    <= {16'd0, width_nxt} * {16'd0, height_nxt};
    end
  end

  // --------------------------------------------------------------------------
  // Decode state
  // --------------------------------------------------------------------------
  logic [7:0]  packet_left_r, packet_left_nxt;
  logic        packet_raw_r,  packet_raw_nxt;
  logic [1:0]  byte_pos_r,    byte_pos_nxt;
  logic [23:0] held_r,        held_nxt;
  logic [31:0] done_r,        done_nxt;

  logic                 in_xfer;
  logic                 four;
  logic [1:0]           last_pos;
  logic                 is_header;
  logic                 is_gather;
  logic                 emit;
  logic [32:0]          diff;
  logic                 total_gt;
  logic [31:0]          remaining;
  logic                 rem_small;
  logic [7:0]           rep;
  logic                 last;
  tga_rle_pkg::result_t res;

  assign in_xfer   = in_valid && !in_stall;
  assign four      = bpp_r[2];
  assign last_pos  = four ? 2'd3 : 2'd2;
  assign is_header = rle_mode_r && (packet_left_r == 8'd0);
  assign is_gather = !is_header && (byte_pos_r < last_pos);
  assign emit      = in_xfer && !is_header && !is_gather;

  // pixels left in the image, at least one
  assign diff      = {1'b0, total_r} - {1'b0, done_r};
  assign total_gt  = !diff[32] && (diff[31:0] != 32'd0);
  assign remaining = total_gt ? diff[31:0] : 32'd1;
  assign rem_small = (remaining[31:8] == 24'd0);

  // repeat count: runs are clipped to what is left of the image
  always_comb begin
    if (rle_mode_r && !packet_raw_r) begin
      if (!rem_small || (packet_left_r < remaining[7:0])) rep = packet_left_r;
      else rep = remaining[7:0];
    end else begin
      rep = 8'd1;
    end
  end

  assign last = rem_small && (rep >= remaining[7:0]);

  // result record for the current byte
  always_comb begin
    res.red          = four ? held_r[23:16] : in_byte;
    res.green        = held_r[15:8];
    res.blue         = held_r[7:0];
    res.alpha        = four ? in_byte : 8'd0;
    res.repeat_count = rep;
    res.image_last   = last;
  end

  // next decode state
  always_comb begin
    packet_left_nxt = packet_left_r;
    packet_raw_nxt  = packet_raw_r;
    byte_pos_nxt    = byte_pos_r;
    held_nxt        = held_r;
    done_nxt        = done_r;
    if (in_xfer) begin
      if (is_header) begin
        packet_raw_nxt  = !in_byte[7];
        packet_left_nxt = in_byte[7] ? (in_byte - tga_rle_pkg::RUN_BIAS) : (in_byte + 8'd1);
        byte_pos_nxt    = 2'd0;
      end else if (is_gather) begin
        case (byte_pos_r)
          2'd0:    held_nxt = {16'd0, in_byte};
          2'd1:    held_nxt = {held_r[23:16], in_byte, held_r[7:0]};
          default: held_nxt = {in_byte, held_r[15:0]};
        endcase
        byte_pos_nxt = byte_pos_r + 2'd1;
      end else if (last) begin
        packet_left_nxt = 8'd0;
        packet_raw_nxt  = 1'b0;
        byte_pos_nxt    = 2'd0;
        held_nxt        = 24'd0;
        done_nxt        = 32'd0;
      end else begin
        if (rle_mode_r) begin
          packet_left_nxt = packet_raw_r ? (packet_left_r - 8'd1) : 8'd0;
        end
        done_nxt     = done_r + {24'd0, rep};
        byte_pos_nxt = 2'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      packet_left_r <= 8'd0;
      packet_raw_r  <= 1'b0;
      byte_pos_r    <= 2'd0;
      held_r        <= 24'd0;
      done_r        <= 32'd0;
    end else begin
      packet_left_r <= packet_left_nxt;
      packet_raw_r  <= packet_raw_nxt;
      byte_pos_r    <= byte_pos_nxt;
      held_r        <= held_nxt;
      done_r        <= done_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Output register with skid stage
  // --------------------------------------------------------------------------
  logic                 out_valid_r;
  logic                 skid_valid_r;
  tga_rle_pkg::result_t out_r;
  tga_rle_pkg::result_t skid_r;
  logic                 out_free;

  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = skid_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (out_free) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= emit;
      end else begin
        out_valid_r  <= emit;
      end
    end else if (emit) begin
      skid_valid_r <= 1'b1;
    end
  end

  // payload moves without reset
  always_ff @(posedge clk) begin
    if (out_free) begin
      if (skid_valid_r) begin
        out_r <= skid_r;
        if (emit) skid_r <= res;
      end else if (emit) begin
        out_r <= res;
      end
    end else if (emit) begin
      skid_r <= res;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_red          = out_r.red;
  assign out_green        = out_r.green;
  assign out_blue         = out_r.blue;
  assign out_alpha        = out_r.alpha;
  assign out_repeat_count = out_r.repeat_count;
  assign out_image_last   = out_r.image_last;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  // skid stage only fills behind a held output register
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid register full while output register empty");

  // every result covers at least one pixel
  a_rep_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_r.repeat_count != 8'd0))
    else $error("result with zero repeat count");

  // finishing an image restarts the pixel count
  a_image_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (emit && last) |=> (done_r == 32'd0) && (packet_left_r == 8'd0))
    else $error("state not cleared after end of image");

endmodule
